// ----- rtl/dbrs_pkg.sv -----
// shared types, constants and helper functions of the batching request scheduler
package dbrs_pkg;

    localparam int QDEPTH      = 32;
    localparam int TICK_BITS   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(QDEPTH);
    localparam int CNT_W       = $clog2(QDEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ENG_RUNNING  = 2'd0,
        ENG_DRAINING = 2'd1,
        ENG_STOPPED  = 2'd2,
        ENG_FAILED   = 2'd3
    } eng_t;

    typedef enum logic [1:0] {
        POL_REJECT      = 2'd0,
        POL_RETRY       = 2'd1,
        POL_DROP_OLDEST = 2'd2,
        POL_DROP_NEWEST = 2'd3
    } policy_t;

    typedef enum logic [3:0] {
        KIND_ACCEPTED    = 4'd0,
        KIND_REJECTED    = 4'd1,
        KIND_RETRY       = 4'd2,
        KIND_DROPPED     = 4'd3,
        KIND_NOT_RUNNING = 4'd4,
        KIND_CANCELLED   = 4'd5,
        KIND_TIMED_OUT   = 4'd6,
        KIND_FAILED      = 4'd7,
        KIND_BATCH       = 4'd8,
        KIND_CANCEL_HIT  = 4'd9,
        KIND_CANCEL_MISS = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_NEW    = 2'd1,
        SRC_CANCEL = 2'd2,
        SRC_ENTRY  = 2'd3
    } id_src_t;

    localparam logic [2:0] CFG_CAPACITY = 3'd0;
    localparam logic [2:0] CFG_POLICY   = 3'd1;
    localparam logic [2:0] CFG_MAXBATCH = 3'd2;
    localparam logic [2:0] CFG_PREFMASK = 3'd3;
    localparam logic [2:0] CFG_MAXWAIT  = 3'd4;
    localparam logic [2:0] CFG_INFLIGHT = 3'd5;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        engine_state;
        logic signed [7:0] req_priority;
        logic [15:0]       compat_key;
        logic [15:0]       deadline_ticks;
        logic [31:0]       cancel_id;
    } request_t;

    typedef struct packed {
        logic [3:0]  result_kind;
        logic [31:0] result_id;
        logic [5:0]  batch_size;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [31:0]       id;
        logic signed [7:0] prio;
        logic [15:0]       key;
        tick_t             submit;
        tick_t             deadline;
        logic              has_deadline;
        logic              cancelled;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] capacity;
        policy_t          policy;
        logic [5:0]       max_batch;
        logic [31:0]      pref_mask;
        logic [15:0]      wait_limit;
        logic [4:0]       max_inflight;
    } cfg_t;

    typedef struct packed {
        logic    latch;
        logic    tick_inc;
        logic    idx_clr;
        logic    idx_inc;
        logic    remove;
        logic    append;
        logic    next_id_inc;
        logic    mark_cancel;
        logic    seed_step;
        logic    gather_clr;
        logic    gather_step;
        logic    decide;
        logic    taken_inc;
        logic    inflight_inc;
        logic    inflight_dec;
        logic    emit;
        kind_t   emit_kind;
        id_src_t emit_src;
        logic    emit_size;
        logic    flush;
    } dp_cmd_t;

    typedef struct packed {
        op_t     opcode;
        eng_t    engine;
        policy_t policy;
        logic    idx_lt_count;
        logic    n_full;
        logic    n_zero;
        logic    count_zero;
        logic    q_full;
        logic    q_at_depth;
        logic    inflight_full;
        logic    e_cancelled;
        logic    e_expired;
        logic    e_cancel_hit;
        logic    e_seed_match;
        logic    taken_done;
        logic    go;
    } dp_status_t;

    function automatic tick_t sat_add(tick_t a, logic [15:0] b);
        logic [TICK_BITS:0] s;
        s = {1'b0, a} + (TICK_BITS + 1)'(b);
        return s[TICK_BITS] ? '1 : s[TICK_BITS-1:0];
    endfunction

    // position plus one of the highest set bit, zero when none
    function automatic logic [5:0] hi_plus1(logic [31:0] v);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            if (v[k])
            begin
                r = 6'(k + 1);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/dbrs_cfg.sv -----
// configuration registers with clamped working values
module dbrs_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output dbrs_pkg::cfg_t       cfg
);
    logic [5:0]  capacity_reg;
    logic [1:0]  policy_reg;
    logic [5:0]  max_batch_reg;
    logic [31:0] pref_mask_reg;
    logic [15:0] wait_limit_reg;
    logic [4:0]  max_inflight_reg;
    logic [6:0]  cap_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= 6'd32;
            policy_reg       <= 2'd0;
            max_batch_reg    <= 6'd8;
            pref_mask_reg    <= '0;
            wait_limit_reg   <= 16'd10;
            max_inflight_reg <= 5'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dbrs_pkg::CFG_CAPACITY: capacity_reg     <= cfg_data[5:0];
                dbrs_pkg::CFG_POLICY:   policy_reg       <= cfg_data[1:0];
                dbrs_pkg::CFG_MAXBATCH: max_batch_reg    <= cfg_data[5:0];
                dbrs_pkg::CFG_PREFMASK: pref_mask_reg    <= cfg_data;
                dbrs_pkg::CFG_MAXWAIT:  wait_limit_reg   <= cfg_data[15:0];
                dbrs_pkg::CFG_INFLIGHT: max_inflight_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cap_wide = {1'b0, capacity_reg};
        if (cap_wide == 7'd0)
        begin
            cap_wide = 7'd1;
        end
        else if (cap_wide > 7'(dbrs_pkg::QDEPTH))
        begin
            cap_wide = 7'(dbrs_pkg::QDEPTH);
        end
        cfg.capacity   = dbrs_pkg::CNT_W'(cap_wide);
        cfg.policy     = dbrs_pkg::policy_t'(policy_reg);
        cfg.pref_mask  = pref_mask_reg;
        cfg.wait_limit = wait_limit_reg;
        if (max_batch_reg == 6'd0)
        begin
            cfg.max_batch = 6'd1;
        end
        else if (max_batch_reg > 6'd32)
        begin
            cfg.max_batch = 6'd32;
        end
        else
        begin
            cfg.max_batch = max_batch_reg;
        end
        if (max_inflight_reg == 5'd0)
        begin
            cfg.max_inflight = 5'd1;
        end
        else if (max_inflight_reg > 5'd16)
        begin
            cfg.max_inflight = 5'd16;
        end
        else
        begin
            cfg.max_inflight = max_inflight_reg;
        end
    end

endmodule

// ----- rtl/dbrs_datapath.sv -----
// request queue, counters, scan datapath and result staging
module dbrs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dbrs_pkg::request_t   request,
    input  dbrs_pkg::cfg_t       cfg,
    input  dbrs_pkg::dp_cmd_t    cmd,
    output dbrs_pkg::dp_status_t status,
    output logic                 result_valid,
    output dbrs_pkg::result_t    result
);
    dbrs_pkg::entry_t                q_reg [dbrs_pkg::QDEPTH];
    dbrs_pkg::request_t              req_reg;
    logic [dbrs_pkg::CNT_W-1:0]      count_reg;
    logic [dbrs_pkg::CNT_W-1:0]      idx_reg;
    logic [dbrs_pkg::NRES_W-1:0]     n_reg;
    logic [31:0]                     next_id_reg;
    logic [31:0]                     new_id_reg;
    dbrs_pkg::tick_t                 now_reg;
    logic [4:0]                      inflight_reg;
    logic signed [7:0]               seed_prio_reg;
    logic [15:0]                     seed_key_reg;
    logic [5:0]                      cc_reg;
    dbrs_pkg::tick_t                 dl_min_reg;
    logic [5:0]                      cnt_reg;
    logic [5:0]                      taken_reg;
    logic                            go_reg;
    logic                            pend_valid_reg;
    dbrs_pkg::result_t               pend_reg;
    logic                            out_valid_reg;
    dbrs_pkg::result_t               out_reg;

    dbrs_pkg::entry_t                e;
    dbrs_pkg::eng_t                  eng;
    logic                            draining;
    dbrs_pkg::tick_t                 w;
    dbrs_pkg::tick_t                 cand;
    logic [5:0]                      cnt_c;
    logic [5:0]                      cnt_final;
    logic [5:0]                      pref;
    logic [5:0]                      target;
    logic [31:0]                     pm;
    logic                            go_c;
    logic [31:0]                     emit_id;
    dbrs_pkg::entry_t                new_entry;

    assign e        = q_reg[idx_reg[dbrs_pkg::IDX_W-1:0]];
    assign eng      = dbrs_pkg::eng_t'(req_reg.engine_state);
    assign draining = (eng == dbrs_pkg::ENG_DRAINING) || (eng == dbrs_pkg::ENG_STOPPED);

    always_comb
    begin
        w    = dbrs_pkg::sat_add(e.submit, cfg.wait_limit);
        cand = (e.has_deadline && e.deadline < w) ? e.deadline : w;

        cnt_c = (cc_reg < cfg.max_batch) ? cc_reg : cfg.max_batch;
        for (int k = 0; k < 32; k++)
        begin
            pm[k] = cfg.pref_mask[k] && (6'(k) < cnt_c);
        end
        pref      = dbrs_pkg::hi_plus1(pm);
        cnt_final = cnt_c;
        if (!draining && cfg.pref_mask != '0 && pref != 6'd0)
        begin
            cnt_final = pref;
        end
        target = (cfg.pref_mask != '0) ? dbrs_pkg::hi_plus1(cfg.pref_mask) : cfg.max_batch;
        go_c   = draining || (cc_reg >= target) || (now_reg >= dl_min_reg);

        unique case (cmd.emit_src)
            dbrs_pkg::SRC_ZERO:   emit_id = '0;
            dbrs_pkg::SRC_NEW:    emit_id = new_id_reg;
            dbrs_pkg::SRC_CANCEL: emit_id = req_reg.cancel_id;
            dbrs_pkg::SRC_ENTRY:  emit_id = e.id;
            default:              emit_id = '0;
        endcase

        new_entry.id           = new_id_reg;
        new_entry.prio         = req_reg.req_priority;
        new_entry.key          = req_reg.compat_key;
        new_entry.submit       = now_reg;
        new_entry.deadline     = dbrs_pkg::sat_add(now_reg, req_reg.deadline_ticks);
        new_entry.has_deadline = (req_reg.deadline_ticks != 16'd0);
        new_entry.cancelled    = 1'b0;
    end

    always_comb
    begin
        status.opcode        = dbrs_pkg::op_t'(req_reg.opcode);
        status.engine        = eng;
        status.policy        = cfg.policy;
        status.idx_lt_count  = idx_reg < count_reg;
        status.n_full        = n_reg >= dbrs_pkg::NRES_W'(dbrs_pkg::MAX_RESULTS);
        status.n_zero        = n_reg == '0;
        status.count_zero    = count_reg == '0;
        status.q_full        = count_reg >= cfg.capacity;
        status.q_at_depth    = count_reg >= dbrs_pkg::CNT_W'(dbrs_pkg::QDEPTH);
        status.inflight_full = inflight_reg >= cfg.max_inflight;
        status.e_cancelled   = e.cancelled;
        status.e_expired     = e.has_deadline && (e.deadline <= now_reg);
        status.e_cancel_hit  = (e.id == req_reg.cancel_id) && !e.cancelled;
        status.e_seed_match  = (e.prio == seed_prio_reg) && (e.key == seed_key_reg);
        status.taken_done    = taken_reg >= cnt_reg;
        status.go            = go_reg;
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (cmd.remove)
        begin
            for (int j = 0; j < dbrs_pkg::QDEPTH - 1; j++)
            begin
                if (dbrs_pkg::CNT_W'(j) >= idx_reg)
                begin
                    q_reg[j] <= q_reg[j+1];
                end
            end
        end
        else if (cmd.append)
        begin
            q_reg[count_reg[dbrs_pkg::IDX_W-1:0]] <= new_entry;
        end
        else if (cmd.mark_cancel)
        begin
            q_reg[idx_reg[dbrs_pkg::IDX_W-1:0]].cancelled <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg    <= request;
            new_id_reg <= next_id_reg;
        end
        if (cmd.seed_step && (idx_reg == '0 || e.prio > seed_prio_reg))
        begin
            seed_prio_reg <= e.prio;
            seed_key_reg  <= e.key;
        end
        if (cmd.gather_clr)
        begin
            cc_reg     <= '0;
            dl_min_reg <= '1;
        end
        else if (cmd.gather_step && status.e_seed_match)
        begin
            cc_reg <= cc_reg + 6'd1;
            if (cand < dl_min_reg)
            begin
                dl_min_reg <= cand;
            end
        end
        if (cmd.decide)
        begin
            cnt_reg   <= cnt_final;
            go_reg    <= go_c;
            taken_reg <= '0;
        end
        else if (cmd.taken_inc)
        begin
            taken_reg <= taken_reg + 6'd1;
        end
        if (cmd.emit)
        begin
            pend_reg.result_kind <= cmd.emit_kind;
            pend_reg.result_id   <= emit_id;
            pend_reg.batch_size  <= cmd.emit_size ? cnt_reg : 6'd0;
            pend_reg.last_of_run <= 1'b0;
        end
        if (cmd.emit || cmd.flush)
        begin
            out_reg <= {pend_reg.result_kind, pend_reg.result_id, pend_reg.batch_size,
                        cmd.flush};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            next_id_reg    <= '0;
            now_reg        <= '0;
            inflight_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.remove)
            begin
                count_reg <= count_reg - dbrs_pkg::CNT_W'(1);
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + dbrs_pkg::CNT_W'(1);
            end
            if (cmd.latch || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + dbrs_pkg::CNT_W'(1);
            end
            if (cmd.latch)
            begin
                n_reg <= '0;
            end
            else if (cmd.emit)
            begin
                n_reg <= n_reg + dbrs_pkg::NRES_W'(1);
            end
            if (cmd.next_id_inc)
            begin
                next_id_reg <= next_id_reg + 32'd1;
            end
            if (cmd.tick_inc && now_reg != '1)
            begin
                now_reg <= now_reg + dbrs_pkg::TICK_BITS'(1);
            end
            if (cmd.inflight_inc)
            begin
                inflight_reg <= inflight_reg + 5'd1;
            end
            else if (cmd.inflight_dec && inflight_reg != '0)
            begin
                inflight_reg <= inflight_reg - 5'd1;
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= (cmd.emit || cmd.flush) && pend_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/dbrs_ctrl.sv -----
// sequencing state machine for submit, cancel, tick and finish requests
module dbrs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dbrs_pkg::dp_status_t status,
    output dbrs_pkg::dp_cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SUBMIT,
        S_APPEND,
        S_CANCEL,
        S_TICK,
        S_PRUNE,
        S_FAIL,
        S_SEED,
        S_GATHER,
        S_DECIDE,
        S_CHECK,
        S_BATCH,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    busy_next  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.opcode)
                    dbrs_pkg::OP_SUBMIT: state_next = S_SUBMIT;
                    dbrs_pkg::OP_CANCEL: state_next = S_CANCEL;
                    dbrs_pkg::OP_TICK:   state_next = S_TICK;
                    dbrs_pkg::OP_FINISH:
                    begin
                        cmd.inflight_dec = 1'b1;
                        state_next       = S_FLUSH;
                    end
                    default: state_next = S_FLUSH;
                endcase
            end
            S_SUBMIT:
            begin
                state_next = S_FLUSH;
                cmd.emit_src = dbrs_pkg::SRC_NEW;
                if (status.engine != dbrs_pkg::ENG_RUNNING)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = dbrs_pkg::KIND_NOT_RUNNING;
                    cmd.emit_src  = dbrs_pkg::SRC_ZERO;
                end
                else
                begin
                    cmd.next_id_inc = 1'b1;
                    if (status.q_full)
                    begin
                        cmd.emit = 1'b1;
                        unique case (status.policy)
                            dbrs_pkg::POL_REJECT:      cmd.emit_kind = dbrs_pkg::KIND_REJECTED;
                            dbrs_pkg::POL_RETRY:       cmd.emit_kind = dbrs_pkg::KIND_RETRY;
                            dbrs_pkg::POL_DROP_NEWEST: cmd.emit_kind = dbrs_pkg::KIND_DROPPED;
                            dbrs_pkg::POL_DROP_OLDEST:
                            begin
                                cmd.emit_kind = dbrs_pkg::KIND_DROPPED;
                                cmd.emit_src  = dbrs_pkg::SRC_ENTRY;
                                cmd.remove    = 1'b1;
                                state_next    = S_APPEND;
                            end
                            default: cmd.emit_kind = dbrs_pkg::KIND_REJECTED;
                        endcase
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_src = dbrs_pkg::SRC_NEW;
                if (status.q_at_depth)
                begin
                    cmd.emit_kind = dbrs_pkg::KIND_REJECTED;
                end
                else
                begin
                    cmd.append    = 1'b1;
                    cmd.emit_kind = dbrs_pkg::KIND_ACCEPTED;
                end
                state_next = S_FLUSH;
            end
            S_CANCEL:
            begin
                cmd.emit_src = dbrs_pkg::SRC_CANCEL;
                if (!status.idx_lt_count)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = dbrs_pkg::KIND_CANCEL_MISS;
                    state_next    = S_FLUSH;
                end
                else if (status.e_cancel_hit)
                begin
                    cmd.mark_cancel = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = dbrs_pkg::KIND_CANCEL_HIT;
                    state_next      = S_FLUSH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_TICK:
            begin
                cmd.tick_inc = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_next   = S_PRUNE;
            end
            S_PRUNE:
            begin
                cmd.emit_src = dbrs_pkg::SRC_ENTRY;
                if (status.idx_lt_count && !status.n_full)
                begin
                    if (status.e_cancelled)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = dbrs_pkg::KIND_CANCELLED;
                        cmd.remove    = 1'b1;
                    end
                    else if (status.e_expired)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = dbrs_pkg::KIND_TIMED_OUT;
                        cmd.remove    = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    priority if (!status.n_zero)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (status.engine == dbrs_pkg::ENG_FAILED)
                    begin
                        state_next = S_FAIL;
                    end
                    else if (status.count_zero || status.inflight_full)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_SEED;
                    end
                end
            end
            S_FAIL:
            begin
                cmd.emit_src = dbrs_pkg::SRC_ENTRY;
                if (!status.count_zero && !status.n_full)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = dbrs_pkg::KIND_FAILED;
                    cmd.remove    = 1'b1;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_SEED:
            begin
                if (status.idx_lt_count)
                begin
                    cmd.seed_step = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
                else
                begin
                    cmd.idx_clr    = 1'b1;
                    cmd.gather_clr = 1'b1;
                    state_next     = S_GATHER;
                end
            end
            S_GATHER:
            begin
                if (status.idx_lt_count)
                begin
                    cmd.gather_step = 1'b1;
                    cmd.idx_inc     = 1'b1;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.go ? S_BATCH : S_FLUSH;
            end
            S_BATCH:
            begin
                cmd.emit_src = dbrs_pkg::SRC_ENTRY;
                if (status.idx_lt_count && !status.taken_done)
                begin
                    if (status.e_seed_match)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = dbrs_pkg::KIND_BATCH;
                        cmd.emit_size = 1'b1;
                        cmd.remove    = 1'b1;
                        cmd.taken_inc = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.inflight_inc = 1'b1;
                    state_next       = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/dynamic_batching_request_scheduler.sv -----
// top level of the dynamic batching request scheduler
// A request is taken when start is high and busy is low; busy stays high until
// every result of that request has been shown. Results appear one per strobe on
// result_valid and must be taken in that cycle, the last one marked by
// last_of_run. A tick is bounded by the sequencer's walks over the queue
// entries, one entry per cycle: a prune walk and, when it gave no result,
// either a fail walk for a failed engine or a seed walk, a gather walk and
// a batch walk. Configuration writes are always ready and belong while
// busy is low.
module dynamic_batching_request_scheduler (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dbrs_pkg::request_t   request,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 result_valid,
    output dbrs_pkg::result_t    result
);
    dbrs_pkg::cfg_t       cfg;
    dbrs_pkg::dp_cmd_t    cmd;
    dbrs_pkg::dp_status_t status;

    dbrs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbrs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    dbrs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- rtl/dbrs_checker.sv -----
// port level checks of the scheduler, bound to the top level
module dbrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input dbrs_pkg::result_t  result
);
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result shown while not busy");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_of_run |=> !busy)
        else $error("busy after last result");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !result_valid)
        else $error("request taken without going busy");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.result_kind <= 4'd10)
        else $error("result kind out of range");

    a_size_only_batch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind != dbrs_pkg::KIND_BATCH
        |-> result.batch_size == 6'd0)
        else $error("batch size on non batch result");

endmodule

bind dynamic_batching_request_scheduler dbrs_checker u_dbrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ----- bench/scheduler_checker.sv -----
// checker for the batching request scheduler: predicts every result and compares
module scheduler_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  dbrs_pkg::request_t request,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               result_valid,
    input  dbrs_pkg::result_t  result,
    output int                 errors,
    output int                 pending
);
    import dbrs_pkg::*;

    localparam longint TMAX = 64'hFFFF_FFFF;

    logic [31:0]       q_id   [QDEPTH];
    logic signed [7:0] q_prio [QDEPTH];
    logic [15:0]       q_key  [QDEPTH];
    longint            q_sub  [QDEPTH];
    longint            q_dl   [QDEPTH];
    bit                q_hasdl[QDEPTH];
    bit                q_canc [QDEPTH];
    int                qcount;
    logic [31:0]       id_next;
    longint            now;
    int                inflight;

    int                cap, pol, mbatch, mwait, minfl;
    logic [31:0]       pmask;

    result_t           run_q[$];
    result_t           expected[$];

    function automatic longint sat(longint a, longint b);
        return (a + b > TMAX) ? TMAX : a + b;
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void add_result(kind_t k, logic [31:0] id, int size);
        result_t r;
        r.result_kind = k;
        r.result_id   = id;
        r.batch_size  = 6'(size);
        r.last_of_run = 1'b0;
        run_q.insert(run_q.size(), r);
    endfunction

    function void remove_at(int i);
        for (int j = i; j + 1 < qcount; j++)
        begin
            q_id[j]    = q_id[j+1];
            q_prio[j]  = q_prio[j+1];
            q_key[j]   = q_key[j+1];
            q_sub[j]   = q_sub[j+1];
            q_dl[j]    = q_dl[j+1];
            q_hasdl[j] = q_hasdl[j+1];
            q_canc[j]  = q_canc[j+1];
        end
        qcount--;
        q_canc[qcount]  = 0;
        q_hasdl[qcount] = 0;
    endfunction

    function void do_submit(request_t rq);
        logic [31:0] id;
        int c;
        c = clampi(cap, 1, QDEPTH);
        if (eng_t'(rq.engine_state) != ENG_RUNNING)
        begin
            add_result(KIND_NOT_RUNNING, 32'd0, 0);
            return;
        end
        id = id_next;
        id_next = id_next + 32'd1;
        if (qcount >= c)
        begin
            case (policy_t'(pol))
                POL_REJECT:
                begin
                    add_result(KIND_REJECTED, id, 0);
                    return;
                end
                POL_RETRY:
                begin
                    add_result(KIND_RETRY, id, 0);
                    return;
                end
                POL_DROP_OLDEST:
                begin
                    add_result(KIND_DROPPED, q_id[0], 0);
                    remove_at(0);
                end
                default:
                begin
                    add_result(KIND_DROPPED, id, 0);
                    return;
                end
            endcase
        end
        if (qcount >= QDEPTH)
        begin
            add_result(KIND_REJECTED, id, 0);
            return;
        end
        q_id[qcount]    = id;
        q_prio[qcount]  = rq.req_priority;
        q_key[qcount]   = rq.compat_key;
        q_sub[qcount]   = now;
        q_hasdl[qcount] = rq.deadline_ticks != 16'd0;
        q_dl[qcount]    = sat(now, longint'(rq.deadline_ticks));
        q_canc[qcount]  = 0;
        qcount++;
        add_result(KIND_ACCEPTED, id, 0);
    endfunction

    function void do_tick(eng_t st);
        int i, seed, cc, target, mb, count, taken, pref;
        longint dline, w;
        bit draining;
        logic signed [7:0] sp;
        logic [15:0] sk;
        if (now < TMAX)
        begin
            now++;
        end
        i = 0;
        while (i < qcount && run_q.size() < MAX_RESULTS)
        begin
            if (q_canc[i])
            begin
                add_result(KIND_CANCELLED, q_id[i], 0);
                remove_at(i);
            end
            else if (q_hasdl[i] && q_dl[i] <= now)
            begin
                add_result(KIND_TIMED_OUT, q_id[i], 0);
                remove_at(i);
            end
            else
            begin
                i++;
            end
        end
        if (run_q.size() > 0)
        begin
            return;
        end
        if (st == ENG_FAILED)
        begin
            while (qcount > 0 && run_q.size() < MAX_RESULTS)
            begin
                add_result(KIND_FAILED, q_id[0], 0);
                remove_at(0);
            end
            return;
        end
        if (qcount == 0 || inflight >= clampi(minfl, 1, 16))
        begin
            return;
        end
        seed = 0;
        for (i = 1; i < qcount; i++)
        begin
            if (q_prio[i] > q_prio[seed])
            begin
                seed = i;
            end
        end
        sp = q_prio[seed];
        sk = q_key[seed];
        cc = 0;
        dline = sat(q_sub[seed], longint'(mwait));
        for (i = 0; i < qcount; i++)
        begin
            if (q_prio[i] == sp && q_key[i] == sk)
            begin
                cc++;
                w = sat(q_sub[i], longint'(mwait));
                if (w < dline)
                begin
                    dline = w;
                end
                if (q_hasdl[i] && q_dl[i] < dline)
                begin
                    dline = q_dl[i];
                end
            end
        end
        mb = clampi(mbatch, 1, 32);
        target = mb;
        for (i = 0; i < 32; i++)
        begin
            if (pmask[i])
            begin
                target = i + 1;
            end
        end
        draining = (st == ENG_DRAINING || st == ENG_STOPPED);
        if (!draining && cc < target && now < dline)
        begin
            return;
        end
        count = cc < mb ? cc : mb;
        if (!draining && pmask != 0)
        begin
            pref = 0;
            for (i = 0; i < 32; i++)
            begin
                if (pmask[i] && i + 1 <= count)
                begin
                    pref = i + 1;
                end
            end
            if (pref != 0)
            begin
                count = pref;
            end
        end
        taken = 0;
        i = 0;
        while (i < qcount && taken < count)
        begin
            if (q_prio[i] == sp && q_key[i] == sk)
            begin
                add_result(KIND_BATCH, q_id[i], count);
                remove_at(i);
                taken++;
            end
            else
            begin
                i++;
            end
        end
        inflight++;
    endfunction

    function void predict(request_t rq);
        int i;
        run_q.delete();
        case (op_t'(rq.opcode))
            OP_SUBMIT: do_submit(rq);
            OP_CANCEL:
            begin
                for (i = 0; i < qcount; i++)
                begin
                    if (q_id[i] == rq.cancel_id && !q_canc[i])
                    begin
                        break;
                    end
                end
                if (i < qcount)
                begin
                    q_canc[i] = 1;
                    add_result(KIND_CANCEL_HIT, rq.cancel_id, 0);
                end
                else
                begin
                    add_result(KIND_CANCEL_MISS, rq.cancel_id, 0);
                end
            end
            OP_TICK: do_tick(eng_t'(rq.engine_state));
            default:
            begin
                if (inflight > 0)
                begin
                    inflight--;
                end
            end
        endcase
        if (run_q.size() > 0)
        begin
            run_q[run_q.size() - 1].last_of_run = 1'b1;
        end
        foreach (run_q[k])
        begin
            expected.insert(expected.size(), run_q[k]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t x;
        if (!rst_n)
        begin
            qcount   = 0;
            id_next  = '0;
            now      = 0;
            inflight = 0;
            cap      = 32;
            pol      = 0;
            mbatch   = 8;
            pmask    = '0;
            mwait    = 10;
            minfl    = 2;
            errors   = 0;
            pending  = 0;
            foreach (q_canc[k])
            begin
                q_canc[k]  = 0;
                q_hasdl[k] = 0;
            end
            expected.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected.size() == 0)
                begin
                    $error("unexpected result kind %0d id %0d", result.result_kind,
                           result.result_id);
                    errors = errors + 1;
                end
                else
                begin
                    x = expected[0];
                    expected.delete(0);
                    if (x.result_kind !== result.result_kind)
                    begin
                        $error("result_kind expected %0d actual %0d", x.result_kind,
                               result.result_kind);
                        errors = errors + 1;
                    end
                    if (x.result_id !== result.result_id)
                    begin
                        $error("result_id expected %0d actual %0d", x.result_id,
                               result.result_id);
                        errors = errors + 1;
                    end
                    if (x.batch_size !== result.batch_size)
                    begin
                        $error("batch_size expected %0d actual %0d", x.batch_size,
                               result.batch_size);
                        errors = errors + 1;
                    end
                    if (x.last_of_run !== result.last_of_run)
                    begin
                        $error("last_of_run expected %0d actual %0d", x.last_of_run,
                               result.last_of_run);
                        errors = errors + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY: cap    = int'(cfg_data[5:0]);
                    CFG_POLICY:   pol    = int'(cfg_data[1:0]);
                    CFG_MAXBATCH: mbatch = int'(cfg_data[5:0]);
                    CFG_PREFMASK: pmask  = cfg_data;
                    CFG_MAXWAIT:  mwait  = int'(cfg_data[15:0]);
                    CFG_INFLIGHT: minfl  = int'(cfg_data[4:0]);
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                predict(request);
            end
            pending = expected.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// testbench top: drives requests and configuration, gives the verdict
module testbench;
    import dbrs_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic     result_valid;
    result_t  result;
    int       errors;
    int       pending;
    int       quiet;
    int       submits;
    bit       no_gaps;

    dynamic_batching_request_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    scheduler_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // no handshake of any kind for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= 5000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic request_t mk(op_t op, eng_t eng, int prio, int key, int dl,
                                    logic [31:0] cid);
        request_t r;
        r.opcode         = op;
        r.engine_state   = eng;
        r.req_priority   = 8'(prio);
        r.compat_key     = 16'(key);
        r.deadline_ticks = 16'(dl);
        r.cancel_id      = cid;
        return r;
    endfunction

    task automatic send(request_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (r.opcode == OP_SUBMIT && r.engine_state == ENG_RUNNING)
        begin
            submits++;
        end
        request <= r;
        start   <= 1'b1;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    // drain all results, lower start, let the sequencer settle
    task automatic settle();
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        repeat (200) @(posedge clk);
    endtask

    function automatic request_t random_request();
        int sel;
        eng_t eng;
        int prio, key, dl;
        logic [31:0] cid;
        sel = $urandom_range(0, 99);
        eng = ENG_RUNNING;
        if ($urandom_range(0, 99) < 12)
        begin
            eng = eng_t'($urandom_range(1, 3));
            if (eng == ENG_FAILED && $urandom_range(0, 2) != 0)
            begin
                eng = ENG_DRAINING;
            end
        end
        prio = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, 2) * 3 - 2;
        key  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: dl = 0;
            6, 7, 8: dl = $urandom_range(1, 20);
            default: dl = $urandom_range(0, 65535);
        endcase
        cid = ($urandom_range(0, 3) == 0) ? $urandom()
                                          : 32'(submits - $urandom_range(1, 6));
        if (sel < 45)
        begin
            return mk(OP_SUBMIT, eng, prio, key, dl, $urandom());
        end
        else if (sel < 80)
        begin
            return mk(OP_TICK, eng, prio, key, dl, $urandom());
        end
        else if (sel < 92)
        begin
            return mk(OP_CANCEL, eng, prio, key, dl, cid);
        end
        return mk(OP_FINISH, eng, prio, key, dl, cid);
    endfunction

    initial
    begin
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 0;
        submits   = 0;
        no_gaps   = 0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, cancel hit and miss, expiry, batch, failed-engine tick on an empty queue
        send(mk(OP_SUBMIT, ENG_RUNNING, 127, 0, 0, 0));
        send(mk(OP_SUBMIT, ENG_RUNNING, -128, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send(mk(OP_SUBMIT, ENG_RUNNING, 127, 0, 1, 0));
        send(mk(OP_SUBMIT, ENG_DRAINING, 5, 1, 0, 0));
        send(mk(OP_SUBMIT, ENG_RUNNING, 127, 0, 0, 0));
        send(mk(OP_CANCEL, ENG_RUNNING, 0, 0, 0, 1));
        send(mk(OP_CANCEL, ENG_RUNNING, 0, 0, 0, 1));
        send(mk(OP_CANCEL, ENG_RUNNING, 0, 0, 0, 32'hFFFF_FFFF));
        send(mk(OP_TICK, ENG_RUNNING, 0, 0, 0, 0));
        send(mk(OP_TICK, ENG_RUNNING, 0, 0, 0, 0));
        for (int k = 0; k < 10; k++)
        begin
            send(mk(OP_TICK, ENG_RUNNING, 0, 0, 0, 0));
        end
        send(mk(OP_CANCEL, ENG_RUNNING, 0, 0, 0, 0));
        send(mk(OP_FINISH, ENG_RUNNING, 0, 0, 0, 0));
        send(mk(OP_TICK, ENG_FAILED, 0, 0, 0, 0));
        send(mk(OP_FINISH, ENG_STOPPED, 0, 0, 0, 0));
        send(mk(OP_TICK, ENG_STOPPED, 0, 0, 0, 0));
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cfg(CFG_CAPACITY, 32'd2);
                    write_cfg(CFG_POLICY, 32'(POL_REJECT));
                    write_cfg(CFG_MAXBATCH, 32'd0);
                    write_cfg(CFG_PREFMASK, 32'hFFFF_FFFF);
                    write_cfg(CFG_MAXWAIT, 32'd0);
                    write_cfg(CFG_INFLIGHT, 32'd0);
                end
                1:
                begin
                    write_cfg(CFG_CAPACITY, 32'd0);
                    write_cfg(CFG_POLICY, 32'(POL_RETRY));
                    write_cfg(CFG_MAXBATCH, 32'd63);
                    write_cfg(CFG_PREFMASK, 32'd0);
                    write_cfg(CFG_MAXWAIT, 32'd65535);
                    write_cfg(CFG_INFLIGHT, 32'd31);
                end
                2:
                begin
                    write_cfg(CFG_CAPACITY, 32'd4);
                    write_cfg(CFG_POLICY, 32'(POL_DROP_OLDEST));
                    write_cfg(CFG_MAXBATCH, 32'd3);
                    write_cfg(CFG_PREFMASK, $urandom());
                    write_cfg(CFG_MAXWAIT, 32'd3);
                    write_cfg(CFG_INFLIGHT, 32'd1);
                end
                3:
                begin
                    write_cfg(CFG_CAPACITY, 32'd3);
                    write_cfg(CFG_POLICY, 32'(POL_DROP_NEWEST));
                    write_cfg(CFG_MAXBATCH, 32'd32);
                    write_cfg(CFG_PREFMASK, 32'h0000_0005);
                    write_cfg(CFG_MAXWAIT, 32'd5);
                    write_cfg(CFG_INFLIGHT, 32'd16);
                end
                4:
                begin
                    write_cfg(CFG_CAPACITY, 32'd63);
                    write_cfg(CFG_POLICY, 32'(POL_DROP_OLDEST));
                    write_cfg(CFG_MAXBATCH, 32'd2);
                    write_cfg(CFG_PREFMASK, 32'h8000_0000);
                    write_cfg(CFG_MAXWAIT, 32'd8);
                    write_cfg(CFG_INFLIGHT, 32'd2);
                end
                default:
                begin
                    write_cfg(CFG_CAPACITY, 32'd32);
                    write_cfg(CFG_POLICY, 32'(POL_REJECT));
                    write_cfg(CFG_MAXBATCH, 32'd8);
                    write_cfg(CFG_PREFMASK, 32'h0000_0088);
                    write_cfg(CFG_MAXWAIT, 32'd10);
                    write_cfg(CFG_INFLIGHT, 32'd3);
                end
            endcase
            cfg_valid <= 1'b0;
            no_gaps = (ph % 2 == 1);
            for (int k = 0; k < 24; k++)
            begin
                send(random_request());
            end
            no_gaps = 0;
            settle();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
